// File: rtl/assert_macros.svh
// assertion helpers used by the checker file nffc_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nffc_pkg.sv
package nffc_pkg;

  // narrow format codes held in the format register
  typedef enum logic [1:0] {
    FMT_FP16 = 2'd0,
    FMT_BF16 = 2'd1,
    FMT_E4M3 = 2'd2,
    FMT_NONE = 2'd3
  } fmt_e;

  // transaction opcodes
  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  // exponent rebias offsets and limits
  localparam logic [7:0] FP16_BIAS_ADJ = 8'd112;
  localparam logic [7:0] E4M3_BIAS_ADJ = 8'd120;
  localparam logic [7:0] FP16_EXP_TOP  = 8'h1F;
  localparam logic [7:0] E4M3_EXP_TOP  = 8'h0F;
  localparam logic [7:0] FP32_EXP_TOP  = 8'hFF;

  // fixed special codes, sign excluded
  localparam logic [14:0] FP16_INF  = 15'h7C00;
  localparam logic [14:0] FP16_QNAN = 15'h7E00;
  localparam logic [14:0] BF16_QNAN = 15'h7FC0;
  localparam logic [6:0]  E4M3_INF  = 7'h78;
  localparam logic [6:0]  E4M3_QNAN = 7'h7F;
  localparam logic [30:0] FP32_INF  = 31'h7F800000;
  localparam logic [30:0] FP32_QNAN = 31'h7FC00000;

  // unpacked fields, mantissa left aligned to the fp32 position
  typedef struct packed {
    op_e         op;
    fmt_e        fmt;
    logic        sign;
    logic [7:0]  exp;
    logic [22:0] mant;
    logic        exp_zero;
    logic        exp_top;
    logic        mant_nz;
  } fields_t;

  // fields after exponent rebias
  typedef struct packed {
    op_e         op;
    fmt_e        fmt;
    logic        sign;
    logic [7:0]  exp_out;
    logic [22:0] mant;
    logic        exp_zero;
    logic        exp_top;
    logic        mant_nz;
    logic        ovf;
  } rebias_t;

endpackage

// File: rtl/nffc_if.sv
// input channel: opcode and source pattern
interface nffc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] value_bits;

  modport source (output valid, output opcode, output value_bits, input ready);
  modport sink   (input valid, input opcode, input value_bits, output ready);
endinterface

// output channel: converted pattern
interface nffc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;

  modport source (output valid, output result_bits, input ready);
  modport sink   (input valid, input result_bits, output ready);
endinterface

// File: rtl/nffc_unpack.sv
module nffc_unpack import nffc_pkg::*; (
  input  op_e         op_i,
  input  fmt_e        fmt_i,
  input  logic [31:0] value_i,
  output fields_t     fields_o
);

  // split the source pattern by direction and format
  always_comb begin
    fields_o.op   = op_i;
    fields_o.fmt  = fmt_i;
    fields_o.sign = 1'b0;
    fields_o.exp  = '0;
    fields_o.mant = '0;
    fields_o.exp_top = 1'b0;
    if (op_i == OP_ENCODE) begin
      fields_o.sign    = value_i[31];
      fields_o.exp     = value_i[30:23];
      fields_o.mant    = value_i[22:0];
      fields_o.exp_top = (value_i[30:23] == FP32_EXP_TOP);
    end else begin
      unique case (fmt_i)
        FMT_FP16: begin
          fields_o.sign    = value_i[15];
          fields_o.exp     = {3'b000, value_i[14:10]};
          fields_o.mant    = {value_i[9:0], 13'b0};
          fields_o.exp_top = ({3'b000, value_i[14:10]} == FP16_EXP_TOP);
        end
        FMT_BF16: begin
          fields_o.sign    = value_i[15];
          fields_o.exp     = value_i[14:7];
          fields_o.mant    = {value_i[6:0], 16'b0};
          fields_o.exp_top = (value_i[14:7] == FP32_EXP_TOP);
        end
        FMT_E4M3: begin
          fields_o.sign    = value_i[7];
          fields_o.exp     = {4'b0000, value_i[6:3]};
          fields_o.mant    = {value_i[2:0], 20'b0};
          fields_o.exp_top = ({4'b0000, value_i[6:3]} == E4M3_EXP_TOP);
        end
        default: begin
          fields_o.sign    = 1'b0;
        end
      endcase
    end
    fields_o.exp_zero = (fields_o.exp == 8'd0);
    fields_o.mant_nz  = |fields_o.mant;
  end

endmodule

// File: rtl/narrow_float_format_converter_top.sv
// structure: an input transaction reaches result valid through three register stages
// (unpack, exponent rebias, result assembly); the last stage is the output register
// throughput: one transaction per cycle; a stalled output holds the whole pipeline
// reset: asynchronous active low, clears stage valid bits and sets format to fp16
module narrow_float_format_converter_top import nffc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  nffc_in_if.sink     in_i,
  nffc_out_if.source  out_o
);

  fmt_e        fmt_q;
  logic        adv;
  logic        v1_q, v2_q, v3_q;
  fields_t     unp_d, s1_q;
  rebias_t     s2_d, s2_q;
  logic [31:0] res_d, res_q;

  // format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_FP16;
    end else if (cfg_we_i) begin
      fmt_q <= fmt_e'(cfg_wdata_i);
    end
  end

  // pipeline advances unless the output register is full and not taken
  assign adv        = !(v3_q && !out_o.ready);
  assign in_i.ready = adv;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 1: unpack fields
  nffc_unpack u_unpack (
    .op_i     (op_e'(in_i.opcode)),
    .fmt_i    (fmt_q),
    .value_i  (in_i.value_bits),
    .fields_o (unp_d)
  );

  // stage 2: rebias and clamp the exponent, flagging e4m3 encode overflow
  always_comb begin
    s2_d.op       = s1_q.op;
    s2_d.fmt      = s1_q.fmt;
    s2_d.sign     = s1_q.sign;
    s2_d.mant     = s1_q.mant;
    s2_d.exp_zero = s1_q.exp_zero;
    s2_d.exp_top  = s1_q.exp_top;
    s2_d.mant_nz  = s1_q.mant_nz;
    s2_d.exp_out  = s1_q.exp;
    s2_d.ovf      = 1'b0;
    if (s1_q.op == OP_ENCODE) begin
      unique case (s1_q.fmt)
        FMT_FP16: begin
          if (s1_q.exp < FP16_BIAS_ADJ) begin
            s2_d.exp_out = '0;
          end else if (s1_q.exp - FP16_BIAS_ADJ > FP16_EXP_TOP) begin
            s2_d.exp_out = FP16_EXP_TOP;
          end else begin
            s2_d.exp_out = s1_q.exp - FP16_BIAS_ADJ;
          end
        end
        FMT_E4M3: begin
          if (s1_q.exp < E4M3_BIAS_ADJ) begin
            s2_d.exp_out = '0;
          end else begin
            s2_d.exp_out = s1_q.exp - E4M3_BIAS_ADJ;
          end
          s2_d.ovf = (s2_d.exp_out > E4M3_EXP_TOP);
        end
        default: begin
          s2_d.exp_out = s1_q.exp;
        end
      endcase
    end else begin
      unique case (s1_q.fmt)
        FMT_FP16: s2_d.exp_out = s1_q.exp + FP16_BIAS_ADJ;
        FMT_E4M3: s2_d.exp_out = s1_q.exp + E4M3_BIAS_ADJ;
        default:  s2_d.exp_out = s1_q.exp;
      endcase
    end
  end

  // stage 3: assemble the result pattern
  always_comb begin
    res_d = '0;
    if (s2_q.fmt == FMT_NONE) begin
      res_d = '0;
    end else if (s2_q.op == OP_DECODE) begin
      priority if (s2_q.exp_zero) begin
        res_d = {s2_q.sign, 8'd0, s2_q.mant};
      end else if (s2_q.exp_top) begin
        res_d = {s2_q.sign, (s2_q.mant_nz ? FP32_QNAN : FP32_INF)};
      end else begin
        res_d = {s2_q.sign, s2_q.exp_out, s2_q.mant};
      end
    end else begin
      unique case (s2_q.fmt)
        FMT_FP16: begin
          priority if (s2_q.exp_zero) begin
            res_d = {16'd0, s2_q.sign, 5'd0, s2_q.mant[22:13]};
          end else if (s2_q.exp_top) begin
            res_d = {16'd0, s2_q.sign, (s2_q.mant_nz ? FP16_QNAN : FP16_INF)};
          end else begin
            res_d = {16'd0, s2_q.sign, s2_q.exp_out[4:0], s2_q.mant[22:13]};
          end
        end
        FMT_BF16: begin
          if (s2_q.exp_top && s2_q.mant_nz) begin
            res_d = {16'd0, s2_q.sign, BF16_QNAN};
          end else begin
            res_d = {16'd0, s2_q.sign, s2_q.exp_out, s2_q.mant[22:16]};
          end
        end
        FMT_E4M3: begin
          priority if (s2_q.exp_zero) begin
            res_d = {24'd0, s2_q.sign, 4'd0, s2_q.mant[22:20]};
          end else if (s2_q.exp_top) begin
            res_d = {24'd0, s2_q.sign, (s2_q.mant_nz ? E4M3_QNAN : E4M3_INF)};
          end else if (s2_q.ovf) begin
            res_d = {24'd0, s2_q.sign, E4M3_INF};
          end else begin
            res_d = {24'd0, s2_q.sign, s2_q.exp_out[3:0], s2_q.mant[22:20]};
          end
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q  <= unp_d;
      s2_q  <= s2_d;
      res_q <= res_d;
    end
  end

  assign out_o.valid       = v3_q;
  assign out_o.result_bits = res_q;

endmodule

// File: rtl/nffc_checker.sv
`include "assert_macros.svh"

module nffc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_result_bits_i
);

  // a waiting result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  // a stalled result keeps its value
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_result_bits_i), "result changed while stalled")

  // an empty output never blocks the input
  `ASSERT_SAME(a_in_open, clk_i, rst_ni, !out_valid_i, in_ready_i, "input blocked with empty output")

  // with the output draining, an accepted transaction reaches the output through the stage registers
  `ASSERT_NEXT(a_latency, clk_i, rst_ni, (in_valid_i && in_ready_i) ##1 out_ready_i ##1 out_ready_i, out_valid_i, "result missing after three cycles")

endmodule

bind narrow_float_format_converter_top nffc_checker u_nffc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_result_bits_i (out_o.result_bits)
);
